@@ src/dual_encoder_speed_position_assert.svh @@
// assertion macros for the dual encoder speed and position block
// expects clk and rst_n in the scope of the module that uses them
`ifndef DUAL_ENCODER_SPEED_POSITION_ASSERT_SVH
`define DUAL_ENCODER_SPEED_POSITION_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DESP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DESP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/desp_pkg.sv @@
// shared types and constants for the dual encoder speed and position block
// no dependencies
`timescale 1ns / 1ps

package desp_pkg;

    // request kinds
    typedef enum logic [1:0] {
        FUNC_RIGHT_EDGE = 2'd0,
        FUNC_TICK       = 2'd1,
        FUNC_CLR_LEFT   = 2'd2,
        FUNC_CLR_RIGHT  = 2'd3
    } func_t;

    // default parameter values
    localparam int DEF_SAMPLE_PERIOD_MS = 5;
    localparam int DEF_PULSES_PER_REV   = 13;
    localparam int DEF_COUNTER_BITS     = 16;

    // fixed field widths and scale constants
    localparam int CNT_IN_W     = 16;
    localparam int LEFT_POS_W   = 30;
    localparam int LEFT_SPD_W   = 22;
    localparam int LEFT_RPM_W   = 24;
    localparam int WORD_W       = 32;
    localparam int RPM_FACTOR   = 60;
    localparam int MS_PER_SEC   = 1000;

endpackage

@@ src/dual_encoder_speed_position.sv @@
// dual wheel encoder position, speed and rpm measurement, top level
// depends on desp_pkg and dual_encoder_speed_position_assert.svh
//
//  channel  signals                                   direction  payload
//  request  evt_valid evt_stall func b_level ...      in         func, b_level, counter_value
//  result   res_valid res_stall left_position ...     out        positions, speeds, dirs, rpm
//
// one request accepted per cycle unless evt_stall is high, every request gives one result in order
// the wheel state registers update at the accepting edge, then a stage forms speed*60
// magnitudes and a final stage divides by pulses per rev with a reciprocal multiply
// reset clears both wheels to zero position and speed, forward direction
// a stalled result backs up through the three stages before evt_stall rises
`timescale 1ns / 1ps

`include "dual_encoder_speed_position_assert.svh"

module dual_encoder_speed_position
#(
    parameter int SAMPLE_PERIOD_MS = desp_pkg::DEF_SAMPLE_PERIOD_MS,
    parameter int PULSES_PER_REV   = desp_pkg::DEF_PULSES_PER_REV,
    parameter int COUNTER_BITS     = desp_pkg::DEF_COUNTER_BITS
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    evt_valid,
    output logic                                    evt_stall,
    input  logic [1:0]                              func,
    input  logic                                    b_level,
    input  logic [desp_pkg::CNT_IN_W-1:0]           counter_value,

    output logic                                    res_valid,
    input  logic                                    res_stall,
    output logic signed [desp_pkg::LEFT_POS_W-1:0]  left_position,
    output logic signed [desp_pkg::LEFT_SPD_W-1:0]  left_pulse_rate,
    output logic                                    left_direction,
    output logic signed [desp_pkg::WORD_W-1:0]      right_position,
    output logic signed [desp_pkg::WORD_W-1:0]      right_pulse_rate,
    output logic                                    right_direction,
    output logic signed [desp_pkg::LEFT_RPM_W-1:0]  left_rpm,
    output logic signed [desp_pkg::WORD_W-1:0]      right_rpm
);

    import desp_pkg::*;

    // effective counter width seen through the 16-bit input
    localparam int CNT_W = (COUNTER_BITS < CNT_IN_W) ? COUNTER_BITS : CNT_IN_W;
    localparam logic [CNT_IN_W-1:0] CNT_MASK = CNT_IN_W'((longint'(1) << CNT_W) - 1);
    localparam logic signed [33:0] CNT_RANGE = 34'(longint'(1) << COUNTER_BITS);
    localparam logic signed [33:0] CNT_HALF  = 34'(longint'(1) << (COUNTER_BITS - 1));

    localparam int RATE_PPS = MS_PER_SEC / SAMPLE_PERIOD_MS;
    localparam logic [23:0]       RATE_24 = 24'(RATE_PPS);
    localparam logic [WORD_W-1:0] RATE_32 = WORD_W'(RATE_PPS);

    // exact unsigned 32-bit division by pulses per rev: q = (x * RPM_MUL) >> RPM_SHIFT
    localparam int RPM_L     = $clog2(PULSES_PER_REV);
    localparam int RPM_SHIFT = WORD_W + RPM_L;
    localparam logic [32:0] RPM_MUL =
        33'(((longint'(1) << RPM_SHIFT) + longint'(PULSES_PER_REV) - 1) /
            longint'(PULSES_PER_REV));

    // ---------------------------------------------------------------
    // handshake across the three stages
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    logic accept;

    assign rdy3      = !v3_reg || !res_stall;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign evt_stall = !rdy1;
    assign accept    = evt_valid && rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= accept;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // ---------------------------------------------------------------
    // wheel state, stage one
    logic [CNT_IN_W-1:0]          left_last_count_reg, left_last_count_next;
    logic [WORD_W-1:0]            left_accum_reg, left_accum_next;
    logic [LEFT_POS_W-1:0]        left_pos_reg, left_pos_next;
    logic [LEFT_SPD_W-1:0]        left_speed_reg, left_speed_next;
    logic                         left_dir_reg, left_dir_next;
    logic [WORD_W-1:0]            right_pos_reg, right_pos_next;
    logic [WORD_W-1:0]            right_last_pos_reg, right_last_pos_next;
    logic [WORD_W-1:0]            right_speed_reg, right_speed_next;
    logic                         right_dir_reg, right_dir_next;

    logic [CNT_IN_W-1:0]          cnt_cur;
    logic signed [33:0]           cnt_delta_raw;
    logic signed [33:0]           cnt_delta;
    logic [WORD_W-1:0]            accum_sum;
    logic [WORD_W-1:0]            accum_rnd;
    logic [23:0]                  lspd_prod;
    logic [WORD_W-1:0]            right_delta;
    func_t                        func_in;

    assign func_in       = func_t'(func);
    assign cnt_cur       = counter_value & CNT_MASK;
    assign cnt_delta_raw = $signed({18'b0, cnt_cur}) - $signed({18'b0, left_last_count_reg});

    // fold the delta into half the counter range
    always_comb
    begin
        if (cnt_delta_raw > CNT_HALF)
            cnt_delta = cnt_delta_raw - CNT_RANGE;
        else if (cnt_delta_raw < -CNT_HALF)
            cnt_delta = cnt_delta_raw + CNT_RANGE;
        else
            cnt_delta = cnt_delta_raw;
    end

    assign accum_sum = left_accum_reg + cnt_delta[WORD_W-1:0];
    // divide by four toward zero
    assign accum_rnd = accum_sum + (accum_sum[WORD_W-1] ? WORD_W'(3) : WORD_W'(0));
    // low 24 bits of delta*rate are all that survive the divide by four and the 22-bit fit
    assign lspd_prod = 24'(cnt_delta[23:0] * RATE_24) + (cnt_delta[33] ? 24'd3 : 24'd0);
    assign right_delta = right_pos_reg - right_last_pos_reg;

    always_comb
    begin
        left_last_count_next = left_last_count_reg;
        left_accum_next      = left_accum_reg;
        left_pos_next        = left_pos_reg;
        left_speed_next      = left_speed_reg;
        left_dir_next        = left_dir_reg;
        right_pos_next       = right_pos_reg;
        right_last_pos_next  = right_last_pos_reg;
        right_speed_next     = right_speed_reg;
        right_dir_next       = right_dir_reg;
        if (accept)
        begin
            case (func_in)
                FUNC_RIGHT_EDGE:
                begin
                    if (b_level)
                        right_pos_next = right_pos_reg + WORD_W'(1);
                    else
                        right_pos_next = right_pos_reg - WORD_W'(1);
                    right_dir_next = b_level;
                end
                FUNC_TICK:
                begin
                    left_last_count_next = cnt_cur;
                    left_accum_next      = accum_sum;
                    left_pos_next        = accum_rnd[WORD_W-1:2];
                    left_speed_next      = lspd_prod[23:2];
                    if (cnt_delta != '0)
                        left_dir_next = !cnt_delta[33];
                    right_last_pos_next = right_pos_reg;
                    right_speed_next    = WORD_W'(right_delta * RATE_32);
                    if (right_delta != '0)
                        right_dir_next = !right_delta[WORD_W-1];
                end
                FUNC_CLR_LEFT:
                begin
                    left_last_count_next = '0;
                    left_accum_next      = '0;
                    left_pos_next        = '0;
                    left_speed_next      = '0;
                    left_dir_next        = 1'b1;
                end
                FUNC_CLR_RIGHT:
                begin
                    right_pos_next      = '0;
                    right_last_pos_next = '0;
                    right_speed_next    = '0;
                    right_dir_next      = 1'b1;
                end
                default:
                begin
                    left_dir_next = left_dir_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_last_count_reg <= '0;
            left_accum_reg      <= '0;
            left_pos_reg        <= '0;
            left_speed_reg      <= '0;
            left_dir_reg        <= 1'b1;
            right_pos_reg       <= '0;
            right_last_pos_reg  <= '0;
            right_speed_reg     <= '0;
            right_dir_reg       <= 1'b1;
        end
        else
        begin
            left_last_count_reg <= left_last_count_next;
            left_accum_reg      <= left_accum_next;
            left_pos_reg        <= left_pos_next;
            left_speed_reg      <= left_speed_next;
            left_dir_reg        <= left_dir_next;
            right_pos_reg       <= right_pos_next;
            right_last_pos_reg  <= right_last_pos_next;
            right_speed_reg     <= right_speed_next;
            right_dir_reg       <= right_dir_next;
        end
    end

    // ---------------------------------------------------------------
    // stage two: snapshot and speed*60 magnitudes
    logic [LEFT_POS_W-1:0]  s2_lpos_reg;
    logic [LEFT_SPD_W-1:0]  s2_lspd_reg;
    logic                   s2_ldir_reg;
    logic [WORD_W-1:0]      s2_rpos_reg;
    logic [WORD_W-1:0]      s2_rspd_reg;
    logic                   s2_rdir_reg;
    logic [WORD_W-1:0]      s2_lmag_reg, s2_lmag_next;
    logic                   s2_lneg_reg;
    logic [WORD_W-1:0]      s2_rmag_reg, s2_rmag_next;
    logic                   s2_rneg_reg;

    logic signed [27:0]     lrpm_prod;
    logic [WORD_W-1:0]      rrpm_prod;

    assign lrpm_prod = 28'($signed(left_speed_reg)) * 28'sd60;
    assign rrpm_prod = WORD_W'(right_speed_reg * WORD_W'(RPM_FACTOR));

    always_comb
    begin
        if (lrpm_prod[27])
            s2_lmag_next = WORD_W'(-lrpm_prod);
        else
            s2_lmag_next = WORD_W'(lrpm_prod);
        if (rrpm_prod[WORD_W-1])
            s2_rmag_next = WORD_W'(0) - rrpm_prod;
        else
            s2_rmag_next = rrpm_prod;
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            s2_lpos_reg <= left_pos_reg;
            s2_lspd_reg <= left_speed_reg;
            s2_ldir_reg <= left_dir_reg;
            s2_rpos_reg <= right_pos_reg;
            s2_rspd_reg <= right_speed_reg;
            s2_rdir_reg <= right_dir_reg;
            s2_lmag_reg <= s2_lmag_next;
            s2_lneg_reg <= lrpm_prod[27];
            s2_rmag_reg <= s2_rmag_next;
            s2_rneg_reg <= rrpm_prod[WORD_W-1];
        end
    end

    // ---------------------------------------------------------------
    // stage three: reciprocal divide and result register
    logic [64:0]            lq_prod, rq_prod;
    logic [WORD_W-1:0]      lq, rq;
    logic [WORD_W-1:0]      lrpm_next, rrpm_next;

    logic [LEFT_POS_W-1:0]  out_lpos_reg;
    logic [LEFT_SPD_W-1:0]  out_lspd_reg;
    logic                   out_ldir_reg;
    logic [WORD_W-1:0]      out_rpos_reg;
    logic [WORD_W-1:0]      out_rspd_reg;
    logic                   out_rdir_reg;
    logic [LEFT_RPM_W-1:0]  out_lrpm_reg;
    logic [WORD_W-1:0]      out_rrpm_reg;

    assign lq_prod   = 65'(s2_lmag_reg) * 65'(RPM_MUL);
    assign rq_prod   = 65'(s2_rmag_reg) * 65'(RPM_MUL);
    assign lq        = WORD_W'(lq_prod >> RPM_SHIFT);
    assign rq        = WORD_W'(rq_prod >> RPM_SHIFT);
    assign lrpm_next = s2_lneg_reg ? (WORD_W'(0) - lq) : lq;
    assign rrpm_next = s2_rneg_reg ? (WORD_W'(0) - rq) : rq;

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            out_lpos_reg <= s2_lpos_reg;
            out_lspd_reg <= s2_lspd_reg;
            out_ldir_reg <= s2_ldir_reg;
            out_rpos_reg <= s2_rpos_reg;
            out_rspd_reg <= s2_rspd_reg;
            out_rdir_reg <= s2_rdir_reg;
            out_lrpm_reg <= lrpm_next[LEFT_RPM_W-1:0];
            out_rrpm_reg <= rrpm_next;
        end
    end

    assign res_valid        = v3_reg;
    assign left_position    = $signed(out_lpos_reg);
    assign left_pulse_rate  = $signed(out_lspd_reg);
    assign left_direction   = out_ldir_reg;
    assign right_position   = $signed(out_rpos_reg);
    assign right_pulse_rate = $signed(out_rspd_reg);
    assign right_direction  = out_rdir_reg;
    assign left_rpm         = $signed(out_lrpm_reg);
    assign right_rpm        = $signed(out_rrpm_reg);

    // ---------------------------------------------------------------
    // assertions
    `DESP_ASSERT_NOW(a_empty_no_stall, !v1_reg, !evt_stall, "stall with empty first stage")
    `DESP_ASSERT_NEXT(a_clr_left, accept && func_in == FUNC_CLR_LEFT, left_accum_reg == '0 && left_last_count_reg == '0 && left_dir_reg, "left clear failed")
    `DESP_ASSERT_NEXT(a_clr_right, accept && func_in == FUNC_CLR_RIGHT, right_pos_reg == '0 && right_speed_reg == '0 && right_dir_reg, "right clear failed")
    `DESP_ASSERT_NEXT(a_tick_last_pos, accept && func_in == FUNC_TICK, right_last_pos_reg == right_pos_reg, "right last position not taken on tick")

endmodule

@@ tb/sv/desp_snapshot_checker.sv @@
// checker for the dual encoder speed and position block: watches both channels,
// predicts each wheel snapshot and compares results in order; depends on desp_pkg
`timescale 1ns / 1ps

module desp_snapshot_checker
(
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    evt_valid,
    input  logic                                    evt_stall,
    input  logic [1:0]                              func,
    input  logic                                    b_level,
    input  logic [desp_pkg::CNT_IN_W-1:0]           counter_value,

    input  logic                                    res_valid,
    input  logic                                    res_stall,
    input  logic signed [desp_pkg::LEFT_POS_W-1:0]  left_position,
    input  logic signed [desp_pkg::LEFT_SPD_W-1:0]  left_pulse_rate,
    input  logic                                    left_direction,
    input  logic signed [desp_pkg::WORD_W-1:0]      right_position,
    input  logic signed [desp_pkg::WORD_W-1:0]      right_pulse_rate,
    input  logic                                    right_direction,
    input  logic signed [desp_pkg::LEFT_RPM_W-1:0]  left_rpm,
    input  logic signed [desp_pkg::WORD_W-1:0]      right_rpm,

    output int                                      fail_cnt,
    output int                                      pending_cnt
);

    import desp_pkg::*;

    localparam int     RATE     = MS_PER_SEC / DEF_SAMPLE_PERIOD_MS;
    localparam int     PPR      = DEF_PULSES_PER_REV;
    localparam int     CNT_W    = DEF_COUNTER_BITS;
    localparam longint CNT_SPAN = longint'(1) << CNT_W;
    localparam longint CNT_HALF = CNT_SPAN / 2;

    typedef struct {
        logic signed [LEFT_POS_W-1:0] l_pos;
        logic signed [LEFT_SPD_W-1:0] l_spd;
        logic                         l_dir;
        logic signed [WORD_W-1:0]     r_pos;
        logic signed [WORD_W-1:0]     r_spd;
        logic                         r_dir;
        logic signed [LEFT_RPM_W-1:0] l_rpm;
        logic signed [WORD_W-1:0]     r_rpm;
    } wheel_snapshot_t;

    logic [CNT_W-1:0]              l_last;
    logic [WORD_W-1:0]             l_accum;
    logic signed [LEFT_POS_W-1:0]  l_pos;
    logic signed [LEFT_SPD_W-1:0]  l_spd;
    logic                          l_dir;
    logic [WORD_W-1:0]             r_pos;
    logic [WORD_W-1:0]             r_last;
    logic [WORD_W-1:0]             r_spd;
    logic                          r_dir;

    wheel_snapshot_t snapshot_q[$];

    task automatic clear_left_wheel();
        l_last  = '0;
        l_accum = '0;
        l_pos   = '0;
        l_spd   = '0;
        l_dir   = 1'b1;
    endtask

    task automatic clear_right_wheel();
        r_pos  = '0;
        r_last = '0;
        r_spd  = '0;
        r_dir  = 1'b1;
    endtask

    task automatic advance_wheels(input func_t f, input logic b,
                                  input logic [CNT_IN_W-1:0] cv,
                                  output wheel_snapshot_t s);
        longint                   delta;
        logic [WORD_W-1:0]        r_delta;
        logic signed [WORD_W-1:0] r_prod;
        case (f)
            FUNC_RIGHT_EDGE:
            begin
                r_pos = b ? r_pos + 1'b1 : r_pos - 1'b1;
                r_dir = b;
            end
            FUNC_TICK:
            begin
                delta = longint'(cv[CNT_W-1:0]) - longint'(l_last);
                // fold into half range, exactly half is kept as is
                if (delta > CNT_HALF)
                    delta -= CNT_SPAN;
                else if (delta < -CNT_HALF)
                    delta += CNT_SPAN;
                l_last  = cv[CNT_W-1:0];
                l_accum = l_accum + delta[WORD_W-1:0];
                l_pos   = LEFT_POS_W'(longint'(signed'(l_accum)) / 4);
                l_spd   = LEFT_SPD_W'(delta * RATE / 4);
                if (delta > 0)
                    l_dir = 1'b1;
                else if (delta < 0)
                    l_dir = 1'b0;
                r_delta = r_pos - r_last;
                r_last  = r_pos;
                r_spd   = r_delta * RATE;
                if (signed'(r_delta) > 0)
                    r_dir = 1'b1;
                else if (r_delta != 0)
                    r_dir = 1'b0;
            end
            FUNC_CLR_LEFT:
                clear_left_wheel();
            default:
                clear_right_wheel();
        endcase
        // right product wraps at 32 bits before the divide
        r_prod  = r_spd * RPM_FACTOR;
        s.l_pos = l_pos;
        s.l_spd = l_spd;
        s.l_dir = l_dir;
        s.r_pos = r_pos;
        s.r_spd = r_spd;
        s.r_dir = r_dir;
        s.l_rpm = LEFT_RPM_W'(longint'(l_spd) * RPM_FACTOR / PPR);
        s.r_rpm = WORD_W'(longint'(r_prod) / PPR);
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        wheel_snapshot_t snap;
        if (!rst_n)
        begin
            clear_left_wheel();
            clear_right_wheel();
            snapshot_q.delete();
            fail_cnt    = 0;
            pending_cnt = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (snapshot_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_cnt++;
                end
                else
                begin
                    snap = snapshot_q.pop_front();
                    check_field("left_position", snap.l_pos, left_position);
                    check_field("left_pulse_rate", snap.l_spd, left_pulse_rate);
                    check_field("left_direction", snap.l_dir, left_direction);
                    check_field("right_position", snap.r_pos, right_position);
                    check_field("right_pulse_rate", snap.r_spd, right_pulse_rate);
                    check_field("right_direction", snap.r_dir, right_direction);
                    check_field("left_rpm", snap.l_rpm, left_rpm);
                    check_field("right_rpm", snap.r_rpm, right_rpm);
                end
            end
            if (evt_valid && !evt_stall)
            begin
                advance_wheels(func_t'(func), b_level, counter_value, snap);
                snapshot_q.push_back(snap);
            end
            pending_cnt = snapshot_q.size();
        end
    end

endmodule

@@ tb/sv/tb_dual_encoder_speed_position.sv @@
// top of the dual encoder speed and position testbench: clock, reset, request
// stimulus, result stalls and verdict; depends on desp_pkg and desp_snapshot_checker
`timescale 1ns / 1ps

module tb_dual_encoder_speed_position;
    import desp_pkg::*;

    localparam int EVENTS_PER_PHASE = 330;
    localparam int HOLD_CYCLES      = 60;
    localparam int IDLE_LIMIT       = 1000;
    localparam int DRAIN_CYCLES     = 10;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          evt_valid     = 1'b0;
    logic                          evt_stall;
    logic [1:0]                    func          = FUNC_RIGHT_EDGE;
    logic                          b_level       = 1'b0;
    logic [CNT_IN_W-1:0]           counter_value = '0;
    logic                          res_valid;
    logic                          res_stall     = 1'b0;
    logic signed [LEFT_POS_W-1:0]  left_position;
    logic signed [LEFT_SPD_W-1:0]  left_pulse_rate;
    logic                          left_direction;
    logic signed [WORD_W-1:0]      right_position;
    logic signed [WORD_W-1:0]      right_pulse_rate;
    logic                          right_direction;
    logic signed [LEFT_RPM_W-1:0]  left_rpm;
    logic signed [WORD_W-1:0]      right_rpm;

    int                  fail_cnt;
    int                  pending_cnt;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  forward_pct    = 50;
    bit                  hold_req       = 1'b0;
    int                  quiet_cycles   = 0;
    logic [CNT_IN_W-1:0] last_count     = '0;

    always #4 clk = ~clk;

    dual_encoder_speed_position dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .evt_valid        (evt_valid),
        .evt_stall        (evt_stall),
        .func             (func),
        .b_level          (b_level),
        .counter_value    (counter_value),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .left_position    (left_position),
        .left_pulse_rate  (left_pulse_rate),
        .left_direction   (left_direction),
        .right_position   (right_position),
        .right_pulse_rate (right_pulse_rate),
        .right_direction  (right_direction),
        .left_rpm         (left_rpm),
        .right_rpm        (right_rpm)
    );

    desp_snapshot_checker snapshot_check
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .evt_valid        (evt_valid),
        .evt_stall        (evt_stall),
        .func             (func),
        .b_level          (b_level),
        .counter_value    (counter_value),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .left_position    (left_position),
        .left_pulse_rate  (left_pulse_rate),
        .left_direction   (left_direction),
        .right_position   (right_position),
        .right_pulse_rate (right_pulse_rate),
        .right_direction  (right_direction),
        .left_rpm         (left_rpm),
        .right_rpm        (right_rpm),
        .fail_cnt         (fail_cnt),
        .pending_cnt      (pending_cnt)
    );

    // result side: random stalls, or one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !((evt_valid && !evt_stall) || (res_valid && !res_stall)))
            quiet_cycles <= quiet_cycles + 1;
        else
            quiet_cycles <= 0;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("dual_encoder_speed_position test failed");
            $finish;
        end
    end

    task automatic send_event(input func_t f, input logic b, input logic [CNT_IN_W-1:0] cv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            evt_valid <= 1'b0;
            @(posedge clk);
        end
        evt_valid     <= 1'b1;
        func          <= f;
        b_level       <= b;
        counter_value <= cv;
        @(posedge clk);
        while (evt_stall) @(posedge clk);
    endtask

    task automatic send_random_event();
        int                  pick;
        int                  shape;
        logic [CNT_IN_W-1:0] cv;
        pick = $urandom_range(99);
        cv   = CNT_IN_W'($urandom);
        if (pick < 45)
            send_event(FUNC_RIGHT_EDGE, ($urandom_range(99) < forward_pct), cv);
        else if (pick < 86)
        begin
            shape = $urandom_range(9);
            // half small moves, some near the half-range fold, the rest fully random
            if (shape < 5)
                cv = last_count + CNT_IN_W'($urandom_range(400)) - CNT_IN_W'(200);
            else if (shape < 7)
                cv = last_count + CNT_IN_W'(32768) + CNT_IN_W'($urandom_range(4))
                     - CNT_IN_W'(2);
            last_count  = cv;
            forward_pct = $urandom_range(100);
            send_event(FUNC_TICK, 1'($urandom_range(1)), cv);
        end
        else if (pick < 93)
        begin
            last_count = '0;
            send_event(FUNC_CLR_LEFT, 1'($urandom_range(1)), cv);
        end
        else
            send_event(FUNC_CLR_RIGHT, 1'($urandom_range(1)), cv);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // no motion on either side keeps the reset direction, then right edges move the right wheel between ticks
        send_event(FUNC_TICK, 1'b0, 16'h0000);
        send_event(FUNC_RIGHT_EDGE, 1'b1, 16'hFFFF);
        send_event(FUNC_RIGHT_EDGE, 1'b1, 16'h0000);
        send_event(FUNC_RIGHT_EDGE, 1'b0, 16'hFFFF);
        send_event(FUNC_TICK, 1'b1, 16'h0000);
        send_event(FUNC_RIGHT_EDGE, 1'b0, 16'h0000);
        send_event(FUNC_RIGHT_EDGE, 1'b0, 16'h0000);
        send_event(FUNC_RIGHT_EDGE, 1'b0, 16'h0000);
        send_event(FUNC_TICK, 1'b0, 16'h0000);
        send_event(FUNC_TICK, 1'b0, 16'h0000);
        // left deltas at and just past plus and minus half range
        send_event(FUNC_TICK, 1'b0, 16'h8000);
        send_event(FUNC_TICK, 1'b1, 16'h0000);
        send_event(FUNC_TICK, 1'b0, 16'h8001);
        send_event(FUNC_TICK, 1'b1, 16'h0000);
        send_event(FUNC_TICK, 1'b0, 16'hFFFF);
        send_event(FUNC_TICK, 1'b1, 16'h0003);
        send_event(FUNC_RIGHT_EDGE, 1'b1, 16'h0000);
        send_event(FUNC_CLR_LEFT, 1'b1, 16'hFFFF);
        send_event(FUNC_CLR_RIGHT, 1'b0, 16'h0000);
        send_event(FUNC_TICK, 1'b1, 16'hFFFF);
        send_event(FUNC_CLR_LEFT, 1'b0, 16'h0000);
        send_event(FUNC_CLR_RIGHT, 1'b1, 16'hFFFF);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (int i = 0; i < EVENTS_PER_PHASE; i++)
            begin
                // long result hold-off while requests keep coming
                if (phase == 0 && i == 40)
                    hold_req = 1'b1;
                send_random_event();
            end
        end
        evt_valid <= 1'b0;
        recv_stall_pct = 0;

        // let the checker record the last request before waiting on the count
        @(posedge clk);
        while (pending_cnt != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0 && pending_cnt == 0)
            $display("dual_encoder_speed_position test passed");
        else
            $display("dual_encoder_speed_position test failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/desp_pkg.sv
src/dual_encoder_speed_position.sv
tb/sv/desp_snapshot_checker.sv
tb/sv/tb_dual_encoder_speed_position.sv
